/* design/mersenne_twister_generator_unit_defines.svh */
// Assertion macros for the generator's top-level RTL file.
`ifndef MERSENNE_TWISTER_GENERATOR_UNIT_DEFINES_SVH
`define MERSENNE_TWISTER_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clk outside reset
`define MTG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising clk outside reset
`define MTG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/mtg_pkg.sv */
// Constants, types and the tempering function of the MT19937 generator.
package mtg_pkg;

  localparam int WORD_W = 32;
  localparam int N      = 624;
  localparam int M      = 397;
  localparam int IDX_W  = 10;

  localparam logic [WORD_W-1:0] MATRIX_A     = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] UPPER_MASK   = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOWER_MASK   = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
  localparam logic [WORD_W-1:0] INIT1_MULT   = 32'd1664525;
  localparam logic [WORD_W-1:0] INIT2_MULT   = 32'd1566083941;
  localparam logic [WORD_W-1:0] ARRAY_SEED   = 32'd19650218;
  localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd5489;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;

  localparam int KEY_DEPTH_DEF = 64;

  // Item modes
  localparam logic [1:0] MODE_SEED = 2'd0;
  localparam logic [1:0] MODE_DRAW = 2'd1;
  localparam logic [1:0] MODE_KEY  = 2'd2;

  // Multiplier constant select
  localparam logic [1:0] MIX_SEED  = 2'd0;
  localparam logic [1:0] MIX_INIT1 = 2'd1;
  localparam logic [1:0] MIX_INIT2 = 2'd2;

  typedef struct packed {
    logic       en;
    logic [1:0] sel;
  } mix_ctl_t;

  // Output tempering: shifts and masks only
  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

/* design/mtg_mix_unit.sv */
// Shared mixing multiplier: registered low word of (x ^ (x >> 30)) * constant.
module mtg_mix_unit (
  input  logic                        clk,
  input  mtg_pkg::mix_ctl_t           ctl,
  input  logic [mtg_pkg::WORD_W-1:0]  operand,
  output logic [mtg_pkg::WORD_W-1:0]  product
);

  logic [mtg_pkg::WORD_W-1:0] x;
  logic [mtg_pkg::WORD_W-1:0] k;
  logic [mtg_pkg::WORD_W-1:0] prod_lo;

  // Constant select
  always_comb begin
    case (ctl.sel)
      mtg_pkg::MIX_SEED:  k = mtg_pkg::SEED_MULT;
      mtg_pkg::MIX_INIT1: k = mtg_pkg::INIT1_MULT;
      mtg_pkg::MIX_INIT2: k = mtg_pkg::INIT2_MULT;
      default:            k = mtg_pkg::SEED_MULT;
    endcase
  end

  assign x       = operand ^ (operand >> 30);
  assign prod_lo = x * k;  // low 32 bits only

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      product <= prod_lo;
    end
  end

endmodule

/* design/mersenne_twister_generator_unit.sv */
// MT19937 generator top level: sequencer, 624-word state RAM and key store.
// Draw, index < 624: S_DRAW_RD reads, S_DRAW_OUT tempers and loads once the result
// register is free. A draw needing a twist first rewrites each word in S_TWA, S_TWB,
// S_TWC (one state RAM read port). Seed: S_SEED_MUL, S_SEED_WR per word via the
// shared multiplier; key init: S_INIT_R/X/W per step, S_WRAP per wrap. Ready only when idle.
// Reset (rst, synchronous) leaves the generator unseeded with an empty key store.
`include "mersenne_twister_generator_unit_defines.svh"

module mersenne_twister_generator_unit #(
  parameter int KEY_DEPTH = mtg_pkg::KEY_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  mode,
  input  logic [mtg_pkg::WORD_W-1:0]  seed_value,
  input  logic                        last_key,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mtg_pkg::WORD_W-1:0]  random_word
);

  localparam int WORD_W = mtg_pkg::WORD_W;
  localparam int IDX_W  = mtg_pkg::IDX_W;
  localparam int N      = mtg_pkg::N;
  localparam int M      = mtg_pkg::M;
  localparam int CNT_W  = $clog2(KEY_DEPTH + 1);
  localparam int KIDX_W = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int KMAX   = (KEY_DEPTH > N) ? KEY_DEPTH : N;
  localparam int KCNT_W = $clog2(KMAX + 1);

  // Sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SEED0    = 4'd1;
  localparam logic [3:0] S_SEED_MUL = 4'd2;
  localparam logic [3:0] S_SEED_WR  = 4'd3;
  localparam logic [3:0] S_INIT_R   = 4'd4;
  localparam logic [3:0] S_INIT_X   = 4'd5;
  localparam logic [3:0] S_INIT_W   = 4'd6;
  localparam logic [3:0] S_WRAP     = 4'd7;
  localparam logic [3:0] S_FINAL    = 4'd8;
  localparam logic [3:0] S_TW0      = 4'd9;
  localparam logic [3:0] S_TW1      = 4'd10;
  localparam logic [3:0] S_TWA      = 4'd11;
  localparam logic [3:0] S_TWB      = 4'd12;
  localparam logic [3:0] S_TWC      = 4'd13;
  localparam logic [3:0] S_DRAW_RD  = 4'd14;
  localparam logic [3:0] S_DRAW_OUT = 4'd15;

  // Follow-up job after seeding
  localparam logic [1:0] CMD_SEED = 2'd0;
  localparam logic [1:0] CMD_DRAW = 2'd1;
  localparam logic [1:0] CMD_INIT = 2'd2;

  logic [3:0]         state;
  logic [1:0]         cmd;
  logic [IDX_W-1:0]   word_index;
  logic [CNT_W-1:0]   key_count;
  logic [CNT_W-1:0]   key_len;
  logic [WORD_W-1:0]  seed_reg;
  logic [WORD_W-1:0]  p;
  logic [IDX_W-1:0]   i;
  logic [KIDX_W-1:0]  j;
  logic [KCNT_W-1:0]  kcnt;
  logic               pass;
  logic [WORD_W-1:0]  mix;
  logic [WORD_W-1:0]  addend;
  logic [WORD_W-1:0]  cur;
  logic [WORD_W-1:0]  nxt;

  // State RAM and key store
  logic [WORD_W-1:0]  state_mem [N];
  logic [WORD_W-1:0]  key_mem [KEY_DEPTH];
  logic [WORD_W-1:0]  rd_data;
  logic [WORD_W-1:0]  key_rd;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wa;
  logic [WORD_W-1:0]  wd;
  logic               we;
  logic               key_we;

  mtg_pkg::mix_ctl_t  mix_ctl;
  logic [WORD_W-1:0]  product;

  logic               accept;
  logic               out_free;
  logic               key_room;
  logic [CNT_W-1:0]   key_count_inc;
  logic [KCNT_W-1:0]  pass1_len;
  logic [IDX_W-1:0]   kk1;
  logic [IDX_W-1:0]   kkm;
  logic [WORD_W-1:0]  tw_y;
  logic [WORD_W-1:0]  tw_word;
  logic [WORD_W-1:0]  step_word;
  logic [WORD_W-1:0]  seed_word;
  logic [CNT_W-1:0]   j_inc;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign key_room      = key_count < CNT_W'(KEY_DEPTH);
  assign key_count_inc = key_count + CNT_W'(key_room);
  assign key_we        = accept && (mode == mtg_pkg::MODE_KEY) && key_room;
  assign pass1_len     = (KCNT_W'(key_len) > KCNT_W'(N)) ? KCNT_W'(key_len) : KCNT_W'(N);
  assign j_inc         = CNT_W'(j) + CNT_W'(1);

  // Twist neighbor addresses
  assign kk1 = (i == IDX_W'(N - 1)) ? '0 : i + IDX_W'(1);
  assign kkm = (i >= IDX_W'(N - M)) ? i - IDX_W'(N - M) : i + IDX_W'(M);

  assign tw_y      = (cur & mtg_pkg::UPPER_MASK) | (nxt & mtg_pkg::LOWER_MASK);
  assign tw_word   = rd_data ^ (tw_y >> 1) ^ (tw_y[0] ? mtg_pkg::MATRIX_A : '0);
  assign step_word = mix + addend;
  assign seed_word = product + WORD_W'(i);

  // RAM port and multiplier control per state
  always_comb begin
    rd_addr     = i;
    we          = 1'b0;
    wa          = i;
    wd          = seed_word;
    mix_ctl.en  = 1'b0;
    mix_ctl.sel = mtg_pkg::MIX_SEED;
    case (state)
      S_SEED0: begin
        we = 1'b1;
        wa = '0;
        wd = seed_reg;
      end
      S_SEED_MUL: begin
        mix_ctl.en = 1'b1;
      end
      S_SEED_WR: begin
        we = 1'b1;
      end
      S_INIT_R: begin
        mix_ctl.en  = 1'b1;
        mix_ctl.sel = pass ? mtg_pkg::MIX_INIT2 : mtg_pkg::MIX_INIT1;
      end
      S_INIT_W: begin
        we = 1'b1;
        wd = step_word;
      end
      S_WRAP: begin
        we = 1'b1;
        wa = '0;
        wd = p;
      end
      S_FINAL: begin
        we = 1'b1;
        wa = '0;
        wd = mtg_pkg::UPPER_MASK;
      end
      S_TW0:      rd_addr = '0;
      S_TWA:      rd_addr = kk1;
      S_TWB:      rd_addr = kkm;
      S_TWC: begin
        we = 1'b1;
        wd = tw_word;
      end
      S_DRAW_RD:  rd_addr = word_index;
      S_DRAW_OUT: rd_addr = word_index;
      default: ;
    endcase
  end

  // State RAM: one write, one registered read
  always_ff @(posedge clk) begin
    if (we) begin
      state_mem[wa] <= wd;
    end
    rd_data <= state_mem[rd_addr];
  end

  // Key store: written on key beats, read at j during the first pass
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_count[KIDX_W-1:0]] <= seed_value;
    end
    key_rd <= key_mem[j];
  end

  mtg_mix_unit u_mix (
    .clk     (clk),
    .ctl     (mix_ctl),
    .operand (p),
    .product (product)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      word_index <= IDX_W'(N + 1);
      key_count  <= '0;
      out_valid  <= 1'b0;
    end else begin
      // Result register empties on its output beat unless refilled below
      if (out_valid && out_ready && state != S_DRAW_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (mode)
              mtg_pkg::MODE_SEED: begin
                seed_reg <= seed_value;
                cmd      <= CMD_SEED;
                state    <= S_SEED0;
              end
              mtg_pkg::MODE_DRAW: begin
                cmd      <= CMD_DRAW;
                seed_reg <= mtg_pkg::DEFAULT_SEED;
                if (word_index > IDX_W'(N)) begin
                  state <= S_SEED0;
                end else if (word_index == IDX_W'(N)) begin
                  state <= S_TW0;
                end else begin
                  state <= S_DRAW_RD;
                end
              end
              mtg_pkg::MODE_KEY: begin
                if (last_key) begin
                  key_len   <= key_count_inc;
                  key_count <= '0;
                  seed_reg  <= mtg_pkg::ARRAY_SEED;
                  cmd       <= CMD_INIT;
                  state     <= S_SEED0;
                end else begin
                  key_count <= key_count_inc;
                end
              end
              default: ;
            endcase
          end
        end
        S_SEED0: begin
          p     <= seed_reg;
          i     <= IDX_W'(1);
          state <= S_SEED_MUL;
        end
        S_SEED_MUL: begin
          state <= S_SEED_WR;
        end
        S_SEED_WR: begin
          if (i == IDX_W'(N - 1)) begin
            word_index <= IDX_W'(N);
            case (cmd)
              CMD_DRAW: state <= S_TW0;
              CMD_INIT: begin
                p     <= mtg_pkg::ARRAY_SEED;
                i     <= IDX_W'(1);
                j     <= '0;
                kcnt  <= pass1_len;
                pass  <= 1'b0;
                state <= S_INIT_R;
              end
              default:  state <= S_IDLE;
            endcase
          end else begin
            p     <= seed_word;
            i     <= i + IDX_W'(1);
            state <= S_SEED_MUL;
          end
        end
        S_INIT_R: begin
          state <= S_INIT_X;
        end
        S_INIT_X: begin
          mix    <= rd_data ^ product;
          addend <= pass ? (WORD_W'(0) - WORD_W'(i)) : (key_rd + WORD_W'(j));
          state  <= S_INIT_W;
        end
        S_INIT_W: begin
          p <= step_word;
          j <= (j_inc >= key_len) ? '0 : j_inc[KIDX_W-1:0];
          if (i == IDX_W'(N - 1)) begin
            kcnt  <= kcnt - KCNT_W'(1);
            i     <= IDX_W'(1);
            state <= S_WRAP;
          end else begin
            i <= i + IDX_W'(1);
            if (kcnt == KCNT_W'(1)) begin
              if (pass) begin
                kcnt  <= '0;
                state <= S_FINAL;
              end else begin
                pass  <= 1'b1;
                kcnt  <= KCNT_W'(N - 1);
                state <= S_INIT_R;
              end
            end else begin
              kcnt  <= kcnt - KCNT_W'(1);
              state <= S_INIT_R;
            end
          end
        end
        S_WRAP: begin
          if (kcnt == '0) begin
            if (pass) begin
              state <= S_FINAL;
            end else begin
              pass  <= 1'b1;
              kcnt  <= KCNT_W'(N - 1);
              state <= S_INIT_R;
            end
          end else begin
            state <= S_INIT_R;
          end
        end
        S_FINAL: begin
          state <= S_IDLE;
        end
        S_TW0: begin
          i     <= '0;
          state <= S_TW1;
        end
        S_TW1: begin
          cur   <= rd_data;
          state <= S_TWA;
        end
        S_TWA: begin
          state <= S_TWB;
        end
        S_TWB: begin
          nxt   <= rd_data;
          state <= S_TWC;
        end
        S_TWC: begin
          cur <= nxt;
          if (i == IDX_W'(N - 1)) begin
            word_index <= '0;
            state      <= S_DRAW_RD;
          end else begin
            i     <= i + IDX_W'(1);
            state <= S_TWA;
          end
        end
        S_DRAW_RD: begin
          state <= S_DRAW_OUT;
        end
        S_DRAW_OUT: begin
          if (out_free) begin
            random_word <= mtg_pkg::temper(rd_data);
            out_valid   <= 1'b1;
            word_index  <= word_index + IDX_W'(1);
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  `MTG_ASSERT_NOW(a_index_range, 1'b1, word_index <= IDX_W'(N + 1), "word index out of range")
  `MTG_ASSERT_NOW(a_draw_index, state == S_DRAW_OUT, word_index < IDX_W'(N), "draw from unseeded or stale state")
  `MTG_ASSERT_NOW(a_key_count, 1'b1, key_count <= CNT_W'(KEY_DEPTH), "key count past store depth")
  `MTG_ASSERT_NOW(a_twist_ctr, state == S_TWC, i < IDX_W'(N), "twist counter out of range")
  `MTG_ASSERT_NEXT(a_draw_done, state == S_DRAW_OUT && out_free, out_valid && state == S_IDLE, "draw result not loaded")

endmodule
